/* design/tcspq_pkg.sv */
package tcspq_pkg;

    localparam int CAPACITY     = 16;
    localparam int NUMBER_WIDTH = 16;
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int SEV_W        = 2;
    localparam int NUM_FIELD_W  = 16;
    localparam int POS_FIELD_W  = 4;
    localparam int CODE_W       = 3;

    typedef logic [NUMBER_WIDTH-1:0] num_t;
    typedef logic [SEV_W-1:0]        sev_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [CODE_W-1:0]       code_t;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_LIST   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    localparam sev_t SEV_BAD = 2'd3;

    localparam code_t RES_OK        = 3'd0;
    localparam code_t RES_NOT_FOUND = 3'd1;
    localparam code_t RES_FULL      = 3'd2;
    localparam code_t RES_BAD_SEV   = 3'd3;
    localparam code_t RES_EMPTY     = 3'd4;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        num_t     num;
        sev_t     sev;
    } cell_cmd_t;

    typedef struct packed {
        num_t num;
        sev_t sev;
    } entry_t;

    // ahead: entry stays ahead of the new key; hit: a match at or left of this cell
    typedef struct packed {
        logic ahead;
        logic hit;
    } link_t;

    typedef enum logic {
        ST_IDLE,
        ST_LIST
    } state_t;

endpackage

/* design/tcspq_cell.sv */
module tcspq_cell
    import tcspq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  entry_t    left_q,
    input  entry_t    right_q,
    input  link_t     link_in,
    output entry_t    entry_q,
    output link_t     link_out
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   stays;
    logic   match;

    assign stays = valid && ((entry_reg.sev < cmd.sev) ||
                   ((entry_reg.sev == cmd.sev) && (entry_reg.num < cmd.num)));
    assign match = valid && (entry_reg.sev == cmd.sev) && (entry_reg.num == cmd.num);

    assign link_out.ahead = stays;
    assign link_out.hit   = link_in.hit | match;
    assign entry_q        = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (!stays) begin
                    if (link_in.ahead) begin
                        entry_next.num = cmd.num;
                        entry_next.sev = cmd.sev;
                    end else begin
                        entry_next = left_q;
                    end
                end
            end
            OP_REMOVE: begin
                if (link_out.hit) begin
                    entry_next = right_q;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

/* design/three_class_sorted_priority_queue.sv */
// Sorted priority queue of up to CAPACITY entries, ordered by severity class
// (0 first) and then by ascending arrival number. Each entry lives in one cell
// of a shift chain; an insert or remove compares the key in every cell at once
// and shifts the whole chain together, so insert and remove take one input
// transfer per cycle while the result register is free. A list request emits
// one entry per cycle from the front while the result register is free, and
// the input is not ready until the last entry has been loaded into the result
// register. s_tuser carries func; results carry the status code on m_tuser and
// mark the final result of each request with m_tlast.
module three_class_sorted_priority_queue
    import tcspq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // arrival_number[15:0], severity[17:16], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // entry_number[15:0], entry_severity[17:16],
                                   // entry_position[21:18], zero pad
    output logic [2:0]  m_tuser,   // result_code[2:0]
    output logic        m_tlast
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    idx_t   idx_reg, idx_next;

    logic                   m_valid_reg, m_valid_next;
    code_t                  m_code_reg, m_code_next;
    logic [NUM_FIELD_W-1:0] m_num_reg, m_num_next;
    sev_t                   m_sev_reg, m_sev_next;
    logic [POS_FIELD_W-1:0] m_pos_reg, m_pos_next;
    logic                   m_last_reg, m_last_next;

    logic      accept;
    logic      out_free;
    logic [1:0] func;
    num_t      num;
    sev_t      sev;
    logic      full;
    logic      found;
    logic      idx_last;
    cell_cmd_t cmd;
    cnt_t      ins_pos;
    cnt_t      rem_pos;
    entry_t    cell_q [CAPACITY];
    link_t     links [CAPACITY+1];
    entry_t    list_q;

    assign func     = s_tuser;
    assign num      = num_t'(s_tdata[15:0]);
    assign sev      = s_tdata[17:16];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == cnt_t'(CAPACITY));
    assign found    = links[CAPACITY].hit;
    assign list_q   = cell_q[idx_reg];
    assign idx_last = (cnt_t'(idx_reg) + cnt_t'(1)) == count_reg;

    assign links[0].ahead = 1'b1;
    assign links[0].hit   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            tcspq_cell u_cell (
                .aclk     (aclk),
                .cmd      (cmd),
                .valid    (cnt_t'(g) < count_reg),
                .left_q   (cell_q[(g == 0) ? 0 : g - 1]),
                .right_q  (cell_q[(g == CAPACITY - 1) ? g : g + 1]),
                .link_in  (links[g]),
                .entry_q  (cell_q[g]),
                .link_out (links[g+1])
            );
        end
    endgenerate

    always_comb begin
        ins_pos = '0;
        rem_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ins_pos = ins_pos + cnt_t'(links[i+1].ahead);
            rem_pos = rem_pos + cnt_t'(!links[i+1].hit);
        end
    end

    always_comb begin
        cmd.op  = OP_HOLD;
        cmd.num = num;
        cmd.sev = sev;
        if (accept && sev != SEV_BAD) begin
            if (func == FUNC_INSERT && !full) begin
                cmd.op = OP_INSERT;
            end else if (func == FUNC_REMOVE && found) begin
                cmd.op = OP_REMOVE;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && func == FUNC_LIST && count_reg != '0) begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST: begin
                if (out_free && idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_code_next  = m_code_reg;
        m_num_next   = m_num_reg;
        m_sev_next   = m_sev_reg;
        m_pos_next   = m_pos_reg;
        m_last_next  = m_last_reg;
        case (cmd.op)
            OP_INSERT: count_next = count_reg + cnt_t'(1);
            OP_REMOVE: count_next = count_reg - cnt_t'(1);
            default:   count_next = count_reg;
        endcase
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (accept && func != FUNC_NONE) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    m_num_next   = NUM_FIELD_W'(num);
                    m_sev_next   = sev;
                    m_pos_next   = '0;
                    if (func == FUNC_LIST) begin
                        m_valid_next = (count_reg == '0);
                        m_code_next  = RES_EMPTY;
                        m_num_next   = '0;
                        m_sev_next   = '0;
                    end else if (sev == SEV_BAD) begin
                        m_code_next = RES_BAD_SEV;
                        m_sev_next  = '0;
                    end else if (func == FUNC_INSERT) begin
                        if (full) begin
                            m_code_next = RES_FULL;
                        end else begin
                            m_code_next = RES_OK;
                            m_pos_next  = POS_FIELD_W'(ins_pos);
                        end
                    end else if (found) begin
                        m_code_next = RES_OK;
                        m_pos_next  = POS_FIELD_W'(rem_pos);
                    end else begin
                        m_code_next = RES_NOT_FOUND;
                    end
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_code_next  = RES_OK;
                    m_num_next   = NUM_FIELD_W'(list_q.num);
                    m_sev_next   = list_q.sev;
                    m_pos_next   = POS_FIELD_W'(idx_reg);
                    m_last_next  = idx_last;
                    idx_next     = idx_reg + idx_t'(1);
                end
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_num_reg  <= m_num_next;
        m_sev_reg  <= m_sev_next;
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_code_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_sev_reg, m_num_reg};

endmodule
